// ===== sv/hplut_pkg.sv =====
`timescale 1ns / 1ps
package hplut_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_SAT        = 2'd1;
    localparam logic [1:0] ST_ZERO_WIDTH = 2'd2;
    localparam logic [1:0] ST_PASS       = 2'd3;

    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_DESCENDING  = 1'b1;

    typedef struct packed {
        logic               func;
        logic [7:0]         entry_index;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [7:0]         segment_index;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic                          is_lookup;
        logic                          wr_ok;
        logic [IDX_W-1:0]              addr;
        logic signed [VALUE_WIDTH-1:0] x;
        logic signed [VALUE_WIDTH-1:0] y;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             desc;
        logic             hint_load;
        logic [IDX_W-1:0] hint_val;
    } t_cfg;

endpackage

// ===== sv/hplut_ram.sv =====
`timescale 1ns / 1ps
module hplut_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/hplut_front.sv =====
`timescale 1ns / 1ps
module hplut_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hplut_pkg::t_in_item i_in_item,
    output logic                o_push,
    output hplut_pkg::t_cmd     o_cmd,
    input  logic                i_full
);
    logic            r_valid, n_valid;
    hplut_pkg::t_cmd r_cmd, n_cmd;
    logic            accept;

    assign o_in_stall = r_valid && i_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_full;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid         = 1'b1;
            n_cmd.is_lookup = (i_in_item.func == hplut_pkg::FUNC_LOOKUP);
            n_cmd.wr_ok     = 32'(i_in_item.entry_index) < hplut_pkg::TABLE_DEPTH;
            n_cmd.addr      = hplut_pkg::IDX_W'(i_in_item.entry_index);
            n_cmd.x         = hplut_pkg::VALUE_WIDTH'(i_in_item.x_value);
            n_cmd.y         = hplut_pkg::VALUE_WIDTH'(i_in_item.y_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end
endmodule

// ===== sv/hplut_queue.sv =====
`timescale 1ns / 1ps
module hplut_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hplut_pkg::t_cmd i_cmd,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output hplut_pkg::t_cmd o_cmd
);
    hplut_pkg::t_cmd               r_slot [hplut_pkg::QUEUE_DEPTH];
    logic [hplut_pkg::QPTR_W-1:0]  r_wptr, r_rptr;
    logic [hplut_pkg::QPTR_W:0]    r_count;

    assign o_full  = r_count == (hplut_pkg::QPTR_W + 1)'(hplut_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end
endmodule

// ===== sv/hplut_back.sv =====
`timescale 1ns / 1ps
module hplut_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hplut_pkg::t_cfg      i_cfg,
    input  logic                 i_valid,
    input  hplut_pkg::t_cmd      i_cmd,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output hplut_pkg::t_out_item o_out_item
);
    localparam int VW = hplut_pkg::VALUE_WIDTH;
    localparam int IW = hplut_pkg::IDX_W;
    localparam int CW = hplut_pkg::CNT_W;
    localparam int SW = VW + 3;
    localparam int DCW = $clog2(2 * VW);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_CMP  = 4'd2;
    localparam logic [3:0] S_RD0  = 4'd3;
    localparam logic [3:0] S_RD1  = 4'd4;
    localparam logic [3:0] S_LD1  = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_RND  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]           r_state;
    logic signed [VW-1:0] r_q, r_xi, r_yi;
    logic [IW-1:0]        r_i, r_hint;
    logic                 r_up, r_pass, r_neg;
    logic [VW-1:0]        r_mdx, r_mdy, r_mdq, r_rem;
    logic [2*VW-1:0]      r_num;
    logic [DCW-1:0]       r_cnt;
    logic [VW-1:0]        r_res;
    logic [1:0]           r_status;
    logic                 r_out_valid;
    hplut_pkg::t_out_item r_out;

    logic [IW-1:0]        raddr;
    logic [VW-1:0]        x_rd, y_rd;
    logic                 wr_en;
    logic [CW-1:0]        lim;
    logic                 up_ok, dn_ok;
    logic signed [VW:0]   dx, dy, dq;
    logic [VW:0]          rem_sh;
    logic                 ge;
    logic                 rnd_inc;
    logic [2*VW:0]        qr;
    logic [SW-1:0]        ysx, qv, sum;
    logic                 ovf;
    logic                 fire;

    assign lim   = i_cfg.count - CW'(2);
    assign wr_en = o_pop && !i_cmd.is_lookup && i_cmd.wr_ok;
    assign raddr = (r_state == S_RD1) ? r_i + 1'b1 : r_i;
    assign o_pop = (r_state == S_IDLE) && i_valid;
    assign fire  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    hplut_ram #(.WIDTH(VW), .DEPTH(hplut_pkg::TABLE_DEPTH)) u_x_ram (
        .i_clk(i_clk), .i_we(wr_en), .i_waddr(i_cmd.addr), .i_wdata(i_cmd.x),
        .i_raddr(raddr), .o_rdata(x_rd)
    );
    hplut_ram #(.WIDTH(VW), .DEPTH(hplut_pkg::TABLE_DEPTH)) u_y_ram (
        .i_clk(i_clk), .i_we(wr_en), .i_waddr(i_cmd.addr), .i_wdata(i_cmd.y),
        .i_raddr(raddr), .o_rdata(y_rd)
    );

    // segment search compares; order flips with the descending flag
    always_comb begin
        up_ok = ({1'b0, r_i} < {1'b0, lim}) &&
                (i_cfg.desc ? (r_q < $signed(x_rd)) : (r_q > $signed(x_rd)));
        dn_ok = (r_i != '0) &&
                (i_cfg.desc ? (r_q > $signed(x_rd)) : (r_q < $signed(x_rd)));
    end

    always_comb begin
        dx = $signed({x_rd[VW-1], x_rd}) - $signed({r_xi[VW-1], r_xi});
        dy = $signed({y_rd[VW-1], y_rd}) - $signed({r_yi[VW-1], r_yi});
        dq = $signed({r_q[VW-1], r_q}) - $signed({r_xi[VW-1], r_xi});
    end

    assign rem_sh = {r_rem, r_num[2*VW-1]};
    assign ge     = rem_sh >= {1'b0, r_mdx};

    // round half away from zero on magnitude, then add and clamp
    always_comb begin
        rnd_inc = {r_rem, 1'b0} >= {1'b0, r_mdx};
        qr      = {1'b0, r_num} + (2 * VW + 1)'(rnd_inc);
        ysx     = SW'(r_yi);
        qv      = SW'(qr[VW:0]);
        sum     = r_neg ? ysx - qv : ysx + qv;
        ovf     = (qr[2*VW:VW+1] != '0) ||
                  (sum[SW-1:VW-1] != '0 && sum[SW-1:VW-1] != '1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hint      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.hint_load) begin
                r_hint <= i_cfg.hint_val;
            end else if (fire && !r_pass) begin
                r_hint <= r_i;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop && i_cmd.is_lookup) begin
                        r_state <= (i_cfg.count < CW'(2)) ? S_DONE : S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if ((r_up && up_ok) || dn_ok) begin
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_RD0;
                    end
                end
                S_RD0: begin
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_state <= S_LD1;
                end
                S_LD1: begin
                    r_state <= (dx == '0) ? S_DONE : S_MUL;
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                r_q    <= i_cmd.x;
                r_up   <= 1'b1;
                r_pass <= i_cfg.count < CW'(2);
                r_res  <= i_cmd.x;
                r_status <= hplut_pkg::ST_PASS;
                if (i_cfg.count < CW'(2)) begin
                    r_i <= '0;
                end else begin
                    r_i <= ({1'b0, r_hint} > {1'b0, lim}) ? IW'(lim) : r_hint;
                end
            end
            S_CMP: begin
                if (r_up && up_ok) begin
                    r_i <= r_i + 1'b1;
                end else begin
                    r_up <= 1'b0;
                    if (dn_ok) begin
                        r_i <= r_i - 1'b1;
                    end
                end
            end
            S_RD1: begin
                r_xi <= x_rd;
                r_yi <= y_rd;
            end
            S_LD1: begin
                r_mdx    <= VW'(dx[VW] ? -dx : dx);
                r_mdy    <= VW'(dy[VW] ? -dy : dy);
                r_mdq    <= VW'(dq[VW] ? -dq : dq);
                r_neg    <= dx[VW] ^ dy[VW] ^ dq[VW];
                r_res    <= r_yi;
                r_status <= hplut_pkg::ST_ZERO_WIDTH;
            end
            S_MUL: begin
                r_num <= r_mdy * r_mdq;
                r_rem <= '0;
                r_cnt <= DCW'(2 * VW - 1);
            end
            S_DIV: begin
                r_num <= {r_num[2*VW-2:0], ge};
                r_rem <= ge ? VW'(rem_sh - {1'b0, r_mdx}) : VW'(rem_sh);
                r_cnt <= r_cnt - 1'b1;
            end
            S_RND: begin
                if (ovf) begin
                    r_res    <= r_neg ? {1'b1, {(VW - 1){1'b0}}} : {1'b0, {(VW - 1){1'b1}}};
                    r_status <= hplut_pkg::ST_SAT;
                end else begin
                    r_res    <= sum[VW-1:0];
                    r_status <= hplut_pkg::ST_OK;
                end
            end
            default: begin
            end
        endcase

        if (fire) begin
            r_out.result_value  <= 32'(r_res);
            r_out.segment_index <= 8'(r_i);
            r_out.status        <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
endmodule

// ===== sv/hinted_piecewise_linear_lut.sv =====
`timescale 1ns / 1ps
// channel   direction  valid        stall        payload
// in        input      i_in_valid   o_in_stall   i_in_item (t_in_item)
// out       output     o_out_valid  i_out_stall  o_out_item (t_out_item)
// cfg       input      psel/penable pready=1     paddr, pwdata, prdata
//
// a write is stored in the table when popped; the back end pops a new command only when idle.
// a lookup on two or more entries searches from the hint one segment per step, then reads the
// segment ends and, unless zero width, multiplies, runs the bit-serial divider and rounds.
// a 2-entry queue lets the input register fill while the back end works.
// reset clears control state only; table contents stay undefined until written.
module hinted_piecewise_linear_lut (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  hplut_pkg::t_in_item               i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output hplut_pkg::t_out_item              o_out_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hplut_pkg::ADDR_W-1:0]      paddr,
    input  logic [hplut_pkg::DATA_W-1:0]      pwdata,
    output logic [hplut_pkg::DATA_W-1:0]      prdata,
    output logic                              pready
);
    localparam int CW = hplut_pkg::CNT_W;

    logic [8:0]      r_entry_count;
    logic            r_desc;
    logic            cfg_wr;
    logic [CW-1:0]   eff_count;
    hplut_pkg::t_cfg cfg;

    logic            push, full, q_valid, pop;
    hplut_pkg::t_cmd f_cmd, q_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_desc        <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[2])
                hplut_pkg::REG_ENTRY_COUNT: r_entry_count <= pwdata[8:0];
                hplut_pkg::REG_DESCENDING:  r_desc        <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            hplut_pkg::REG_ENTRY_COUNT: prdata = hplut_pkg::DATA_W'(r_entry_count);
            hplut_pkg::REG_DESCENDING:  prdata = hplut_pkg::DATA_W'(r_desc);
            default:                    prdata = '0;
        endcase
    end

    assign eff_count = (32'(r_entry_count) > hplut_pkg::TABLE_DEPTH) ?
                       CW'(hplut_pkg::TABLE_DEPTH) : CW'(r_entry_count);

    // new count re-centers the search hint
    always_comb begin
        cfg.count     = eff_count;
        cfg.desc      = r_desc;
        cfg.hint_load = cfg_wr && (paddr[2] == hplut_pkg::REG_ENTRY_COUNT);
        cfg.hint_val  = hplut_pkg::IDX_W'(({1'b0, pwdata[8:0]} > 10'(hplut_pkg::TABLE_DEPTH)
                        ? 10'(hplut_pkg::TABLE_DEPTH) : {1'b0, pwdata[8:0]}) >> 1);
    end

    hplut_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_push(push), .o_cmd(f_cmd), .i_full(full)
    );

    hplut_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_cmd(f_cmd), .o_full(full),
        .o_valid(q_valid), .i_pop(pop), .o_cmd(q_cmd)
    );

    hplut_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg),
        .i_valid(q_valid), .i_cmd(q_cmd), .o_pop(pop),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item)
    );
endmodule

// ===== sv/hplut_checker.sv =====
`timescale 1ns / 1ps
module hplut_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input hplut_pkg::t_out_item o_out_item,
    input logic                 pready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_pass_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == hplut_pkg::ST_PASS
        |-> o_out_item.segment_index == 8'd0 && pready)
        else $error("pass-through with nonzero segment");
endmodule

bind hinted_piecewise_linear_lut hplut_checker u_hplut_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_out_item(o_out_item), .pready(pready)
);
